// ===== rtl/core/pcr_pkg.sv =====
// ----------------------------------------------------------------------------
// pcr_pkg
// shared widths, controller states and the command and status bundles of the
// crossover and repair block
// ----------------------------------------------------------------------------
package pcr_pkg;

   // field widths of the streams
   localparam int GENE_W         = 6;
   localparam int CUT_W          = 7;
   localparam int REQ_DATA_W     = 24;
   localparam int RSP_DATA_W     = 8;

   // a gene can name at most this many cities
   localparam int GENE_CITIES    = 2 ** GENE_W;

   // default tour capacity
   localparam int MAX_CITIES_DEF = 64;

   // controller states
   typedef enum logic [2:0] {
      ST_LOAD      = 3'd0,
      ST_FIND      = 3'd1,
      ST_SWEEP     = 3'd2,
      ST_EMIT_READ = 3'd3,
      ST_EMIT_WAIT = 3'd4
   } state_type;

   // controller to datapath
   typedef struct packed {
      logic load;        // request accepted, store its gene
      logic select;      // commit the chosen missing and duplicate city
      logic sweep;       // read one tail position and advance
      logic emit_start;  // point the read address at position zero
      logic emit_next;   // advance to the next child gene
      logic clear;       // end of job, back to the idle values
   } cmd_type;

   // datapath to controller
   typedef struct packed {
      logic load_end;    // current request is the last position of the tour
      logic found;       // a missing city and a duplicate exist, tail non-empty
      logic addr_last;   // read address sits on the last position
   } status_type;

endpackage

// ===== rtl/core/pcr_ctrl.sv =====
// ----------------------------------------------------------------------------
// pcr_ctrl
// job sequencer: load the tours, alternate search and tail sweeps, then
// stream the child genes out
// ----------------------------------------------------------------------------
module pcr_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   input  pcr_pkg::status_type   status,
   output pcr_pkg::cmd_type      cmd
);

   pcr_pkg::state_type state_ff;
   pcr_pkg::state_type state_in;

   // state register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= pcr_pkg::ST_LOAD;
      end else begin
         state_ff <= state_in;
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         pcr_pkg::ST_LOAD: begin
            if (req_tvalid && status.load_end) begin
               state_in = pcr_pkg::ST_FIND;
            end
         end
         pcr_pkg::ST_FIND: begin
            if (status.found) begin
               state_in = pcr_pkg::ST_SWEEP;
            end else begin
               state_in = pcr_pkg::ST_EMIT_READ;
            end
         end
         pcr_pkg::ST_SWEEP: begin
            if (status.addr_last) begin
               state_in = pcr_pkg::ST_FIND;
            end
         end
         pcr_pkg::ST_EMIT_READ: begin
            state_in = pcr_pkg::ST_EMIT_WAIT;
         end
         pcr_pkg::ST_EMIT_WAIT: begin
            if (rsp_tready) begin
               if (status.addr_last) begin
                  state_in = pcr_pkg::ST_LOAD;
               end else begin
                  state_in = pcr_pkg::ST_EMIT_READ;
               end
            end
         end
         default: begin
            state_in = pcr_pkg::ST_LOAD;
         end
      endcase
   end

   // outputs and datapath commands
   always_comb begin
      req_tready = 1'b0;
      rsp_tvalid = 1'b0;
      cmd        = '0;
      unique case (state_ff)
         pcr_pkg::ST_LOAD: begin
            req_tready = 1'b1;
            cmd.load   = req_tvalid;
         end
         pcr_pkg::ST_FIND: begin
            cmd.select     = status.found;
            cmd.emit_start = !status.found;
         end
         pcr_pkg::ST_SWEEP: begin
            cmd.sweep = 1'b1;
         end
         pcr_pkg::ST_EMIT_READ: begin
         end
         pcr_pkg::ST_EMIT_WAIT: begin
            rsp_tvalid    = 1'b1;
            cmd.clear     = rsp_tready && status.addr_last;
            cmd.emit_next = rsp_tready && !status.addr_last;
         end
         default: begin
         end
      endcase
   end

endmodule

// ===== rtl/core/pcr_dpath.sv =====
// ----------------------------------------------------------------------------
// pcr_dpath
// child store, city occurrence counts, duplicate and missing city search and
// the read-modify-write path of the tail sweep
// ----------------------------------------------------------------------------
module pcr_dpath #(
   parameter int MAX_CITIES = pcr_pkg::MAX_CITIES_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic [pcr_pkg::REQ_DATA_W-1:0]  req_tdata,
   input  logic                            req_tlast,
   input  pcr_pkg::cmd_type                cmd,
   output pcr_pkg::status_type             status,
   output logic [pcr_pkg::RSP_DATA_W-1:0]  rsp_tdata,
   output logic                            rsp_tlast
);

   // positions, lengths, counted cities and stored gene widths
   localparam int AW   = (MAX_CITIES > 1) ? $clog2(MAX_CITIES) : 1;
   localparam int LW   = $clog2(MAX_CITIES + 1);
   localparam int NC   = (MAX_CITIES < pcr_pkg::GENE_CITIES) ?
                         MAX_CITIES : pcr_pkg::GENE_CITIES;
   localparam int CW   = (NC > 1) ? $clog2(NC) : 1;
   localparam int SW   = (AW > pcr_pkg::GENE_W) ? AW : pcr_pkg::GENE_W;
   localparam int CMPW = (LW > pcr_pkg::CUT_W) ? LW : pcr_pkg::CUT_W;
   localparam int GXW  = pcr_pkg::GENE_W + 1;

   // request fields
   logic [pcr_pkg::GENE_W-1:0] first_gene;
   logic [pcr_pkg::GENE_W-1:0] second_gene;
   logic [pcr_pkg::CUT_W-1:0]  cut_field;

   assign first_gene  = req_tdata[pcr_pkg::GENE_W-1:0];
   assign second_gene = req_tdata[2*pcr_pkg::GENE_W-1:pcr_pkg::GENE_W];
   assign cut_field   = req_tdata[2*pcr_pkg::GENE_W+pcr_pkg::CUT_W-1:2*pcr_pkg::GENE_W];

   // job registers
   logic [LW-1:0] len_ff,    len_in;
   logic [LW-1:0] cut_ff,    cut_in;
   logic [LW-1:0] search_ff, search_in;
   logic [LW-1:0] miss_ff,   miss_in;
   logic [CW-1:0] dup_ff,    dup_in;
   logic [AW-1:0] addr_ff,   addr_in;
   logic          wb_ff,     wb_in;
   logic [AW-1:0] wb_addr_ff;
   logic [SW-1:0] rd_data_ff;
   logic [1:0]    cnt_ff [NC];
   logic [1:0]    cnt_in [NC];

   logic [SW-1:0] store [MAX_CITIES];

   // load side
   logic [AW-1:0]              pos;
   logic [pcr_pkg::GENE_W-1:0] gene_sel;
   logic [CMPW-1:0]            cut_wide;
   logic [LW-1:0]              cut_clamped;
   logic                       gene_counted;
   logic [CW-1:0]              gene_idx;

   assign pos          = len_ff[AW-1:0];
   assign gene_sel     = ((len_ff == '0) || (len_ff < cut_ff)) ? first_gene : second_gene;
   assign cut_wide     = CMPW'(cut_field);
   assign gene_counted = GXW'(gene_sel) < GXW'(NC);
   assign gene_idx     = gene_sel[CW-1:0];

   // clamp the cut to one up to the tour capacity
   always_comb begin
      if (cut_wide == '0) begin
         cut_clamped = LW'(1);
      end else if (cut_wide > CMPW'(MAX_CITIES)) begin
         cut_clamped = LW'(MAX_CITIES);
      end else begin
         cut_clamped = LW'(cut_wide);
      end
   end

   // smallest duplicated city below the tour length
   logic          dup_found;
   logic [CW-1:0] dup_idx;

   always_comb begin
      dup_found = 1'b0;
      dup_idx   = '0;
      for (int e = NC - 1; e >= 0; e--) begin
         if ((cnt_ff[e] == 2'd2) && (LW'(e) < len_ff)) begin
            dup_found = 1'b1;
            dup_idx   = CW'(e);
         end
      end
   end

   // next missing city from the search start, cities beyond the counted
   // range are always missing
   logic          miss_tracked;
   logic [CW-1:0] miss_idx;
   logic [LW-1:0] miss_cand;
   logic          miss_ok;

   always_comb begin
      miss_tracked = 1'b0;
      miss_idx     = '0;
      for (int e = NC - 1; e >= 0; e--) begin
         if ((cnt_ff[e] == 2'd0) && (LW'(e) >= search_ff) && (LW'(e) < len_ff)) begin
            miss_tracked = 1'b1;
            miss_idx     = CW'(e);
         end
      end
      if (miss_tracked) begin
         miss_cand = LW'(miss_idx);
      end else if (search_ff > LW'(NC)) begin
         miss_cand = search_ff;
      end else begin
         miss_cand = LW'(NC);
      end
   end

   assign miss_ok = miss_cand < len_ff;

   // status back to the sequencer
   logic addr_last;

   assign addr_last        = (LW'(addr_ff) + LW'(1)) == len_ff;
   assign status.load_end  = req_tlast || (len_ff == LW'(MAX_CITIES - 1));
   assign status.found     = dup_found && miss_ok && (cut_ff < len_ff);
   assign status.addr_last = addr_last;

   // job register next values
   always_comb begin
      len_in    = len_ff;
      cut_in    = cut_ff;
      search_in = search_ff;
      miss_in   = miss_ff;
      dup_in    = dup_ff;
      addr_in   = addr_ff;
      wb_in     = cmd.sweep;
      if (cmd.clear) begin
         len_in    = '0;
         cut_in    = LW'(1);
         search_in = '0;
      end else if (cmd.load) begin
         len_in = len_ff + LW'(1);
         if (len_ff == '0) begin
            cut_in = cut_clamped;
         end
      end
      if (cmd.select) begin
         miss_in   = miss_cand;
         dup_in    = dup_idx;
         search_in = miss_cand + LW'(1);
         addr_in   = cut_ff[AW-1:0];
      end else if (cmd.emit_start) begin
         addr_in = '0;
      end else if (cmd.sweep || cmd.emit_next) begin
         addr_in = addr_ff + AW'(1);
      end
   end

   // occurrence counts, saturating at three
   always_comb begin
      for (int e = 0; e < NC; e++) begin
         cnt_in[e] = cnt_ff[e];
      end
      if (cmd.clear) begin
         for (int e = 0; e < NC; e++) begin
            cnt_in[e] = 2'd0;
         end
      end else if (cmd.load && gene_counted) begin
         if (cnt_ff[gene_idx] != 2'd3) begin
            cnt_in[gene_idx] = cnt_ff[gene_idx] + 2'd1;
         end
      end else if (cmd.select) begin
         cnt_in[dup_idx] = 2'd1;
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         len_ff    <= '0;
         cut_ff    <= LW'(1);
         search_ff <= '0;
         wb_ff     <= 1'b0;
         for (int e = 0; e < NC; e++) begin
            cnt_ff[e] <= 2'd0;
         end
      end else begin
         len_ff    <= len_in;
         cut_ff    <= cut_in;
         search_ff <= search_in;
         wb_ff     <= wb_in;
         for (int e = 0; e < NC; e++) begin
            cnt_ff[e] <= cnt_in[e];
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      miss_ff    <= miss_in;
      dup_ff     <= dup_in;
      addr_ff    <= addr_in;
      wb_addr_ff <= addr_ff;
   end

   // child store: one write port, one registered read port
   logic wb_hit;

   assign wb_hit = wb_ff && (rd_data_ff == SW'(dup_ff));

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         store[pos] <= SW'(gene_sel);
      end else if (wb_hit) begin
         store[wb_addr_ff] <= SW'(miss_ff);
      end
      rd_data_ff <= store[addr_ff];
   end

   // result fields
   assign rsp_tdata = pcr_pkg::RSP_DATA_W'(rd_data_ff[pcr_pkg::GENE_W-1:0]);
   assign rsp_tlast = addr_last;

endmodule

// ===== rtl/core/permutation_crossover_repair.sv =====
// ----------------------------------------------------------------------------
// permutation_crossover_repair
// single point crossover of two tours with repair of the child permutation
// ----------------------------------------------------------------------------
// loading takes one request per cycle; after the last position each repaired
// city costs a search step and a sweep of the tail from the cut to the end,
// plus a final search, as every sweep uses the single read port of the store
// emission then shows each child gene from a registered store read
// one job at a time: no request is taken during repair and emission
// synchronous reset returns to loading with empty counts and a cut of one
module permutation_crossover_repair #(
   parameter int MAX_CITIES = pcr_pkg::MAX_CITIES_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_tvalid,
   output logic                            req_tready,
   // first_parent_gene [5:0], second_parent_gene [11:6], cut_position [18:12]
   input  logic [pcr_pkg::REQ_DATA_W-1:0]  req_tdata,
   input  logic                            req_tlast,
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   // child_gene [5:0]
   output logic [pcr_pkg::RSP_DATA_W-1:0]  rsp_tdata,
   output logic                            rsp_tlast
);

   pcr_pkg::cmd_type    cmd;
   pcr_pkg::status_type status;

   // sequencer
   pcr_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .status     (status),
      .cmd        (cmd)
   );

   // store, counts and search
   pcr_dpath #(
      .MAX_CITIES (MAX_CITIES)
   ) u_dpath (
      .clock     (clock),
      .reset     (reset),
      .req_tdata (req_tdata),
      .req_tlast (req_tlast),
      .cmd       (cmd),
      .status    (status),
      .rsp_tdata (rsp_tdata),
      .rsp_tlast (rsp_tlast)
   );

endmodule

// ===== rtl/core/pcr_checker.sv =====
// ----------------------------------------------------------------------------
// pcr_checker
// port level checks on the request and result streams of the block
// ----------------------------------------------------------------------------
module pcr_checker (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_tvalid,
   input  logic                            req_tready,
   input  logic                            req_tlast,
   input  logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   input  logic [pcr_pkg::RSP_DATA_W-1:0]  rsp_tdata,
   input  logic                            rsp_tlast
);

   // a stalled result holds its payload
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=>
         rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tlast))
      else $error("stalled result changed");

   // no request is taken while results are pending
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> !req_tready)
      else $error("request taken during emission");

   // the last request of a tour starts repair, nothing is shown at once
   assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready && req_tlast |=> !rsp_tvalid && !req_tready)
      else $error("last request not followed by repair");

   // after the final gene the block is ready for the next tour
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tready && rsp_tlast |=> !rsp_tvalid && req_tready)
      else $error("block not back to loading after final gene");

   // reset leaves no result showing
   assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("result valid after reset");

endmodule

bind permutation_crossover_repair pcr_checker u_pcr_checker (.*);
